/* design/vrmtt_pkg.sv */
// Shared types, codes and constants of the variable-range memory-type table.
package vrmtt_pkg;

    // Default table depth handed to the top level.
    localparam int MAX_RANGES_DEF = 8;

    // Address field of base and mask words, and the entry valid bit.
    localparam logic [31:0] ADDR_BITS = 32'hFFFF_F000;
    localparam int          VALID_POS = 11;

    // Size rounding limits for write-combining requests.
    localparam logic [30:0] SIZE_MIN = 31'h0000_1000;
    localparam logic [30:0] SIZE_CAP = 31'h4000_0000;

    // Memory types.
    localparam logic [7:0] TYPE_WC = 8'h01;
    localparam logic [7:0] TYPE_UC = 8'h00;

    // Action codes of an input transaction.
    localparam logic [1:0] ACT_REQUEST  = 2'd0;
    localparam logic [1:0] ACT_LOOKUP   = 2'd1;
    localparam logic [1:0] ACT_LOAD     = 2'd2;
    localparam logic [1:0] ACT_RESERVED = 2'd3;

    // Configuration register indexes.
    localparam int         CFG_IDX_W      = 3;
    localparam logic [2:0] CFG_FEATURE    = 3'd0;
    localparam logic [2:0] CFG_WC_SUPPORT = 3'd1;
    localparam logic [2:0] CFG_ENABLED    = 3'd2;
    localparam logic [2:0] CFG_IN_USE     = 3'd3;
    localparam logic [2:0] CFG_RAM_BYTES  = 3'd4;

    // Result status codes.
    typedef enum logic [3:0] {
        ST_WRITTEN       = 4'd0,
        ST_ALREADY_WC    = 4'd1,
        ST_BAD_ARGS      = 4'd2,
        ST_NO_FEATURE    = 4'd3,
        ST_NO_WC         = 4'd4,
        ST_DISABLED      = 4'd5,
        ST_IN_RAM        = 4'd6,
        ST_UNALIGNED     = 4'd7,
        ST_OTHER_TYPE    = 4'd8,
        ST_NO_FREE       = 4'd9,
        ST_NOT_EFFECTIVE = 4'd10,
        ST_HIT           = 4'd11,
        ST_MISS          = 4'd12,
        ST_LOADED        = 4'd13
    } t_status;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ROUND,
        S_SCAN,
        S_PLACE,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    take;
        logic    grow;
        logic    scan_step;
        logic    write_load;
        logic    write_req;
        logic    set_code;
        t_status code;
        logic    out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] action;
        logic       pre_fail;
        t_status    pre_code;
        logic       grow_more;
        logic       aligned;
        logic       scan_done;
        logic       hit;
        logic       hit_wc;
        logic       hit_other;
        logic       free_found;
        logic       shadowed;
        logic       out_busy;
    } t_dp_sts;

endpackage

/* design/vrmtt_if.sv */
// Channel interfaces of the variable-range memory-type table.

// Input transaction channel.
interface vrmtt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] address;
    logic [31:0] length_bytes;
    logic [2:0]  entry_index;
    logic [31:0] entry_base_word;
    logic [31:0] entry_mask_word;

    modport source (
        output valid, action, address, length_bytes, entry_index,
               entry_base_word, entry_mask_word,
        input  ready
    );
    modport sink (
        input  valid, action, address, length_bytes, entry_index,
               entry_base_word, entry_mask_word,
        output ready
    );
endinterface

// Result transaction channel.
interface vrmtt_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [7:0]  found_type;
    logic [2:0]  slot_used;
    logic [30:0] range_size;

    modport source (
        output valid, status, found_type, slot_used, range_size,
        input  ready
    );
    modport sink (
        input  valid, status, found_type, slot_used, range_size,
        output ready
    );
endinterface

// Configuration write channel.
interface vrmtt_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

/* design/vrmtt_ctrl.sv */
// Controller state machine that sequences one transaction through the datapath.
module vrmtt_ctrl
    import vrmtt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.code = ST_WRITTEN;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.action)
                    ACT_LOAD: begin
                        o_cmd.write_load = 1'b1;
                        o_cmd.set_code   = 1'b1;
                        o_cmd.code       = ST_LOADED;
                        n_state          = S_FINISH;
                    end
                    ACT_LOOKUP: begin
                        n_state = S_SCAN;
                    end
                    ACT_REQUEST: begin
                        if (i_sts.pre_fail) begin
                            o_cmd.set_code = 1'b1;
                            o_cmd.code     = i_sts.pre_code;
                            n_state        = S_FINISH;
                        end else begin
                            n_state = S_ROUND;
                        end
                    end
                    default: begin
                        o_cmd.set_code = 1'b1;
                        o_cmd.code     = ST_BAD_ARGS;
                        n_state        = S_FINISH;
                    end
                endcase
            end
            S_ROUND: begin
                // Double the size one step per cycle until it fits and aligns or hits the cap.
                if (i_sts.grow_more) begin
                    o_cmd.grow = 1'b1;
                end else if (!i_sts.aligned) begin
                    o_cmd.set_code = 1'b1;
                    o_cmd.code     = ST_UNALIGNED;
                    n_state        = S_FINISH;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_sts.scan_done) begin
                    o_cmd.scan_step = 1'b1;
                end else if (i_sts.action == ACT_LOOKUP) begin
                    o_cmd.set_code = 1'b1;
                    o_cmd.code     = i_sts.hit ? ST_HIT : ST_MISS;
                    n_state        = S_FINISH;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                o_cmd.set_code = 1'b1;
                n_state        = S_FINISH;
                if (i_sts.hit_wc) begin
                    o_cmd.code = ST_ALREADY_WC;
                end else if (i_sts.hit_other) begin
                    o_cmd.code = ST_OTHER_TYPE;
                end else if (!i_sts.free_found) begin
                    o_cmd.code = ST_NO_FREE;
                end else begin
                    o_cmd.write_req = 1'b1;
                    o_cmd.code      = i_sts.shadowed ? ST_NOT_EFFECTIVE : ST_WRITTEN;
                end
            end
            S_FINISH: begin
                // Wait for the output register to free up.
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* design/vrmtt_datapath.sv */
// Datapath: configuration, range table, size rounding, table scan and result register.
module vrmtt_datapath
    import vrmtt_pkg::*;
#(
    parameter int MAX_RANGES = MAX_RANGES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input payload
    input  logic [1:0]           i_action,
    input  logic [31:0]          i_address,
    input  logic [31:0]          i_length_bytes,
    input  logic [2:0]           i_entry_index,
    input  logic [31:0]          i_entry_base_word,
    input  logic [31:0]          i_entry_mask_word,
    // Configuration writes
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output logic                 o_cfg_ready,
    // Result channel
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [3:0]           o_status,
    output logic [7:0]           o_found_type,
    output logic [2:0]           o_slot_used,
    output logic [30:0]          o_range_size,
    // Controller link
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts
);

    localparam int         IDX_W  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int         CNT_W  = $clog2(MAX_RANGES + 1);
    localparam logic [4:0] MAX_R5 = 5'(MAX_RANGES);

    // Configuration registers
    logic        r_feature;
    logic        r_wc_support;
    logic        r_enabled;
    logic [3:0]  r_in_use;
    logic [31:0] r_ram_bytes;

    // Transaction registers
    logic [1:0]  r_action;
    logic [31:0] r_addr;
    logic [31:0] r_len;
    logic [2:0]  r_idx;
    logic [31:0] r_bw;
    logic [31:0] r_mw;
    logic [30:0] r_size;
    t_status     r_code;

    // Range table
    logic [31:0] r_base  [MAX_RANGES];
    logic [31:0] r_mask  [MAX_RANGES];
    logic        r_valid [MAX_RANGES];

    // Scan state
    logic [CNT_W-1:0] r_cnt;
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic [7:0]       r_hit_type;
    logic             r_free;
    logic [IDX_W-1:0] r_free_idx;

    // Output register
    logic        r_out_valid;
    t_status     r_o_status;
    logic [7:0]  r_o_type;
    logic [2:0]  r_o_slot;
    logic [30:0] r_o_size;

    logic [31:0]      w_size32;
    logic [31:0]      w_low;
    logic             w_aligned;
    logic [4:0]       w_in_use5;
    logic [CNT_W-1:0] w_lim;
    logic             w_done;
    logic [IDX_W-1:0] w_sel;
    logic             w_match;
    logic [IDX_W-1:0] w_load_idx;
    logic             w_load_ok;
    logic             w_pre_fail;
    t_status          w_pre_code;

    assign o_cfg_ready = 1'b1;

    // Size rounding terms.
    assign w_size32  = {1'b0, r_size};
    assign w_low     = w_size32 - 32'd1;
    assign w_aligned = ((r_addr & w_low) == 32'd0);

    // Number of entries scanned.
    assign w_in_use5 = {1'b0, r_in_use};
    assign w_lim     = (w_in_use5 >= MAX_R5) ? CNT_W'(MAX_R5) : CNT_W'(w_in_use5);
    assign w_done    = (r_cnt >= w_lim);
    assign w_sel     = r_cnt[IDX_W-1:0];
    assign w_match   = (((r_addr ^ r_base[w_sel]) & r_mask[w_sel] & ADDR_BITS) == 32'd0);

    // Load target, ignored when it lies beyond the table.
    assign w_load_idx = IDX_W'(r_idx);
    assign w_load_ok  = ({2'b00, r_idx} < MAX_R5);

    // Request preconditions in priority order.
    always_comb begin
        w_pre_fail = 1'b1;
        w_pre_code = ST_BAD_ARGS;
        if (r_addr == 32'd0 || r_len == 32'd0) begin
            w_pre_code = ST_BAD_ARGS;
        end else if (!r_feature) begin
            w_pre_code = ST_NO_FEATURE;
        end else if (!r_wc_support) begin
            w_pre_code = ST_NO_WC;
        end else if (!r_enabled) begin
            w_pre_code = ST_DISABLED;
        end else if (r_addr < r_ram_bytes) begin
            w_pre_code = ST_IN_RAM;
        end else begin
            w_pre_fail = 1'b0;
        end
    end

    // Status toward the controller.
    always_comb begin
        o_sts.action     = r_action;
        o_sts.pre_fail   = w_pre_fail;
        o_sts.pre_code   = w_pre_code;
        o_sts.grow_more  = ((w_size32 < r_len) || !w_aligned) && (r_size < SIZE_CAP);
        o_sts.aligned    = w_aligned;
        o_sts.scan_done  = w_done;
        o_sts.hit        = r_hit;
        o_sts.hit_wc     = r_hit && (r_hit_type == TYPE_WC);
        o_sts.hit_other  = r_hit && (r_hit_type != TYPE_WC) && (r_hit_type != TYPE_UC);
        o_sts.free_found = r_free;
        o_sts.shadowed   = r_hit && (r_hit_idx < r_free_idx);
        o_sts.out_busy   = r_out_valid && !i_out_ready;
    end

    // Configuration registers and control flags with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feature    <= 1'b0;
            r_wc_support <= 1'b0;
            r_enabled    <= 1'b0;
            r_in_use     <= 4'd8;
            r_ram_bytes  <= 32'd0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < MAX_RANGES; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_FEATURE:    r_feature    <= i_cfg_data[0];
                    CFG_WC_SUPPORT: r_wc_support <= i_cfg_data[0];
                    CFG_ENABLED:    r_enabled    <= i_cfg_data[0];
                    CFG_IN_USE:     r_in_use     <= i_cfg_data[3:0];
                    CFG_RAM_BYTES:  r_ram_bytes  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.write_load && w_load_ok) begin
                r_valid[w_load_idx] <= r_mw[VALID_POS];
            end
            if (i_cmd.write_req) begin
                r_valid[r_free_idx] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Transaction, table payload, scan and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_action <= i_action;
            r_addr   <= i_address;
            r_len    <= i_length_bytes;
            r_idx    <= i_entry_index;
            r_bw     <= i_entry_base_word;
            r_mw     <= i_entry_mask_word;
            r_size   <= SIZE_MIN;
            r_cnt    <= '0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
        end
        if (i_cmd.grow) begin
            r_size <= {r_size[29:0], 1'b0};
        end
        // One entry per cycle: keep the first covering entry and the first free one.
        if (i_cmd.scan_step) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_valid[w_sel] && w_match && !r_hit) begin
                r_hit      <= 1'b1;
                r_hit_idx  <= w_sel;
                r_hit_type <= r_base[w_sel][7:0];
            end
            if (!r_valid[w_sel] && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= w_sel;
            end
        end
        if (i_cmd.write_load && w_load_ok) begin
            r_base[w_load_idx] <= r_bw;
            r_mask[w_load_idx] <= r_mw;
        end
        if (i_cmd.write_req) begin
            r_base[r_free_idx] <= (r_addr & ADDR_BITS) | {24'd0, TYPE_WC};
            r_mask[r_free_idx] <= (~w_low & ADDR_BITS) | (32'd1 << VALID_POS);
        end
        if (i_cmd.set_code) begin
            r_code <= i_cmd.code;
        end
        // Result fields that do not belong to the status read as zero.
        if (i_cmd.out_load) begin
            r_o_status <= r_code;
            r_o_type   <= (r_code == ST_HIT) ? r_hit_type : 8'd0;
            if (r_code == ST_WRITTEN || r_code == ST_NOT_EFFECTIVE) begin
                r_o_slot <= 3'(r_free_idx);
                r_o_size <= r_size;
            end else begin
                r_o_slot <= 3'd0;
                r_o_size <= 31'd0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_o_status;
    assign o_found_type = r_o_type;
    assign o_slot_used  = r_o_slot;
    assign o_range_size = r_o_size;

endmodule

/* design/variable_range_memory_type_table.sv */
// Variable-range memory-type table: top level joining controller and datapath.
//
// Usage: i_in carries one transaction per valid/ready handshake: a load writes
// a table entry, a lookup returns the type of the first valid covering entry,
// and a request installs a write-combining range after its checks. Every input
// transaction yields exactly one result transaction on o_out. i_cfg writes the
// configuration registers by index; it is always ready and should only be
// used while the block is idle.
// After acceptance, a load, a reserved action or a request that fails its
// checks goes from decode to the finish state; a lookup first scans the table;
// a request that passes them rounds its size and, if aligned, scans the table
// and places its entry. The table scan visits one entry per cycle and the size
// rounding doubles the size once per cycle (up to 18 doublings).
// One transaction is in progress at a time; the next one is accepted as soon
// as the result sits in the output register.
// Reset clears the configuration to its defaults and marks every entry
// invalid. If the receiver stalls, the result holds in the output register and
// a finished transaction waits until it can be handed over.
module variable_range_memory_type_table
    import vrmtt_pkg::*;
#(
    parameter int MAX_RANGES = MAX_RANGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vrmtt_in_if.sink    i_in,
    vrmtt_out_if.source o_out,
    vrmtt_cfg_if.sink   i_cfg
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Transaction sequencing.
    vrmtt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Storage and arithmetic.
    vrmtt_datapath #(
        .MAX_RANGES (MAX_RANGES)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_action          (i_in.action),
        .i_address         (i_in.address),
        .i_length_bytes    (i_in.length_bytes),
        .i_entry_index     (i_in.entry_index),
        .i_entry_base_word (i_in.entry_base_word),
        .i_entry_mask_word (i_in.entry_mask_word),
        .i_cfg_valid       (i_cfg.valid),
        .i_cfg_index       (i_cfg.index),
        .i_cfg_data        (i_cfg.data),
        .o_cfg_ready       (i_cfg.ready),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_status          (o_out.status),
        .o_found_type      (o_out.found_type),
        .o_slot_used       (o_out.slot_used),
        .o_range_size      (o_out.range_size),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts)
    );

endmodule

/* design/vrmtt_checker.sv */
// Port-level assertions for the variable-range memory-type table, bound to the top level.
module vrmtt_checker
    import vrmtt_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  i_status,
    input logic [7:0]  i_found_type,
    input logic [2:0]  i_slot_used,
    input logic [30:0] i_range_size
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its fields.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_status) && $stable(i_found_type) &&
            $stable(i_slot_used) && $stable(i_range_size))
        else $error("result changed while stalled");

    // Only one transaction is taken at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted while a transaction is in progress");

    // A memory type is reported only on a lookup hit.
    a_type_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_found_type != 8'd0 |-> i_status == ST_HIT)
        else $error("found type reported without a hit");

    // A written range has a power-of-two size of at least one page.
    a_size_pow2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_WRITTEN || i_status == ST_NOT_EFFECTIVE) |->
            $onehot(i_range_size) && i_range_size[11:0] == 12'd0)
        else $error("written range size is not a valid power of two");

endmodule

bind variable_range_memory_type_table vrmtt_checker u_vrmtt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_status     (o_out.status),
    .i_found_type (o_out.found_type),
    .i_slot_used  (o_out.slot_used),
    .i_range_size (o_out.range_size)
);

/* test/variable_range_memory_type_table_tb.sv */
// Self-checking testbench of the variable-range memory-type table.
`timescale 1ns / 1ps

module variable_range_memory_type_table_tb;
    import vrmtt_pkg::*;

    localparam int DEPTH          = MAX_RANGES_DEF;
    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int BLOCK_ITEMS    = 25;
    localparam int BLOCKS         = 5;
    localparam logic [31:0] VALID_MASK = 32'd1 << VALID_POS;

    // One input transaction.
    typedef struct {
        logic [1:0]  action;
        logic [31:0] address;
        logic [31:0] length_bytes;
        logic [2:0]  entry_index;
        logic [31:0] entry_base_word;
        logic [31:0] entry_mask_word;
    } range_item_t;

    // One result transaction.
    typedef struct packed {
        t_status     status;
        logic [7:0]  found_type;
        logic [2:0]  slot_used;
        logic [30:0] range_size;
    } range_result_t;

    logic i_clk;
    logic i_rst_n;

    vrmtt_in_if  in_ch ();
    vrmtt_out_if out_ch ();
    vrmtt_cfg_if cfg_ch ();

    variable_range_memory_type_table #(
        .MAX_RANGES(DEPTH)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    // Mirror of the range table and the configuration registers.
    logic [31:0] mirror_base [DEPTH];
    logic [31:0] mirror_mask [DEPTH];
    logic        mirror_feature;
    logic        mirror_wc;
    logic        mirror_enabled;
    logic [3:0]  mirror_in_use;
    logic [31:0] mirror_ram;

    range_result_t pending_results[$];
    int mismatch_count;
    int result_count;
    int reg_write_count;
    int action_count [4];
    int status_seen [16];
    int sender_idle_pct;
    int receiver_stall_pct;
    int quiet_cycles;

    // Free-running clock.
    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    // Number of entries that a lookup or a free-slot search visits.
    function automatic int scan_limit();
        return (int'(mirror_in_use) < DEPTH) ? int'(mirror_in_use) : DEPTH;
    endfunction

    // Type of the first valid entry that covers the address.
    function automatic bit find_covering(input logic [31:0] addr, output logic [7:0] mem_type);
        bit hit;
        hit      = 1'b0;
        mem_type = TYPE_UC;
        for (int i = 0; i < scan_limit(); i++) begin
            if (!hit && mirror_mask[i][VALID_POS] &&
                ((addr & mirror_mask[i] & ADDR_BITS) ==
                 (mirror_base[i] & mirror_mask[i] & ADDR_BITS))) begin
                hit      = 1'b1;
                mem_type = mirror_base[i][7:0];
            end
        end
        return hit;
    endfunction

    // Write-combining request: checks, size rounding and entry placement.
    function automatic range_result_t request_write_combining(input logic [31:0] addr,
                                                              input logic [31:0] len);
        range_result_t r;
        logic [31:0]   size;
        logic [7:0]    mem_type;
        bit            hit;
        int            free_slot;
        r.status     = ST_WRITTEN;
        r.found_type = '0;
        r.slot_used  = '0;
        r.range_size = '0;
        if (addr == 32'd0 || len == 32'd0) begin
            r.status = ST_BAD_ARGS;
        end else if (!mirror_feature) begin
            r.status = ST_NO_FEATURE;
        end else if (!mirror_wc) begin
            r.status = ST_NO_WC;
        end else if (!mirror_enabled) begin
            r.status = ST_DISABLED;
        end else if (addr < mirror_ram) begin
            r.status = ST_IN_RAM;
        end else begin
            size = 32'(SIZE_MIN);
            while (size < len && size < 32'(SIZE_CAP)) size = size << 1;
            while ((addr & (size - 32'd1)) != 32'd0 && size < 32'(SIZE_CAP)) size = size << 1;
            hit = find_covering(addr, mem_type);
            if ((addr & (size - 32'd1)) != 32'd0) begin
                r.status = ST_UNALIGNED;
            end else if (hit && mem_type == TYPE_WC) begin
                r.status = ST_ALREADY_WC;
            end else if (hit && mem_type != TYPE_UC) begin
                r.status = ST_OTHER_TYPE;
            end else begin
                free_slot = -1;
                for (int i = 0; i < scan_limit(); i++) begin
                    if (free_slot < 0 && !mirror_mask[i][VALID_POS]) free_slot = i;
                end
                if (free_slot < 0) begin
                    r.status = ST_NO_FREE;
                end else begin
                    mirror_base[free_slot] = (addr & ADDR_BITS) | 32'(TYPE_WC);
                    mirror_mask[free_slot] = (~(size - 32'd1) & ADDR_BITS) | VALID_MASK;
                    r.slot_used  = free_slot[2:0];
                    r.range_size = size[30:0];
                    hit = find_covering(addr, mem_type);
                    // An earlier uncached entry can shadow the new one.
                    r.status = (hit && mem_type == TYPE_WC) ? ST_WRITTEN : ST_NOT_EFFECTIVE;
                end
            end
        end
        return r;
    endfunction

    // Expected result of one transaction; updates the mirror as the block would.
    function automatic range_result_t predict_table_result(input range_item_t it);
        range_result_t r;
        logic [7:0]    mem_type;
        r.status     = ST_BAD_ARGS;
        r.found_type = '0;
        r.slot_used  = '0;
        r.range_size = '0;
        case (it.action)
            ACT_REQUEST: begin
                r = request_write_combining(it.address, it.length_bytes);
            end
            ACT_LOOKUP: begin
                if (find_covering(it.address, mem_type)) begin
                    r.status     = ST_HIT;
                    r.found_type = mem_type;
                end else begin
                    r.status = ST_MISS;
                end
            end
            ACT_LOAD: begin
                if (int'(it.entry_index) < DEPTH) begin
                    mirror_base[it.entry_index] = it.entry_base_word;
                    mirror_mask[it.entry_index] = it.entry_mask_word;
                end
                r.status = ST_LOADED;
            end
            default: begin
                r.status = ST_BAD_ARGS;
            end
        endcase
        return r;
    endfunction

    function automatic range_item_t make_item(input logic [1:0] action, input logic [31:0] addr,
                                              input logic [31:0] len, input logic [2:0] idx,
                                              input logic [31:0] base_word,
                                              input logic [31:0] mask_word);
        range_item_t it;
        it.action          = action;
        it.address         = addr;
        it.length_bytes    = len;
        it.entry_index     = idx;
        it.entry_base_word = base_word;
        it.entry_mask_word = mask_word;
        return it;
    endfunction

    // Random transaction, shaped so that most requests pass their checks.
    function automatic range_item_t random_item();
        range_item_t it;
        int          pick;
        int          k;
        int          j;
        logic [7:0]  mem_type;
        it = make_item(2'($urandom), $urandom, $urandom, 3'($urandom), $urandom, $urandom);
        j    = $urandom_range(0, DEPTH - 1);
        k    = $urandom_range(12, 31);
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            it.action = ACT_RESERVED;
        end else if (pick < 40) begin
            it.action = ACT_REQUEST;
            pick = $urandom_range(0, 99);
            if (pick < 25) it.address = mirror_base[j] & ADDR_BITS;
            else if (pick < 75) it.address = ($urandom & ~((32'd1 << k) - 32'd1)) | (32'd1 << k);
            else if (pick < 85) it.address = $urandom & ADDR_BITS;
            else if (pick < 95) it.address = $urandom;
            else it.address = 32'd0;
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                it.length_bytes = 32'd1 << $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 1) it.length_bytes = it.length_bytes - 32'd1;
            end else if (pick >= 92) begin
                it.length_bytes = 32'd0;
            end
        end else if (pick < 70) begin
            it.action = ACT_LOOKUP;
            if ($urandom_range(0, 1) == 1) begin
                it.address = (mirror_base[j] & ADDR_BITS) | 32'($urandom_range(0, 4095));
            end
        end else begin
            it.action = ACT_LOAD;
            case ($urandom_range(0, 5))
                0:       mem_type = TYPE_UC;
                1:       mem_type = TYPE_WC;
                2:       mem_type = 8'h04;
                3:       mem_type = 8'h05;
                4:       mem_type = 8'h06;
                default: mem_type = 8'($urandom);
            endcase
            if ($urandom_range(0, 99) < 85) begin
                it.entry_base_word = ($urandom & ~((32'd1 << k) - 32'd1) & ADDR_BITS) |
                                     32'(mem_type);
            end
            if ($urandom_range(0, 99) < 85) begin
                it.entry_mask_word = (~((32'd1 << k) - 32'd1) & ADDR_BITS) |
                                     (($urandom_range(0, 99) < 40) ? VALID_MASK : 32'd0);
            end
        end
        return it;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("Mismatch on %s at result %0d: got 0x%0h, expected 0x%0h",
                 field, result_count, got, want);
        mismatch_count++;
    endtask

    // Sends one transaction and records its expected result on acceptance.
    task automatic send_item(input range_item_t it);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.action          = it.action;
        in_ch.address         = it.address;
        in_ch.length_bytes    = it.length_bytes;
        in_ch.entry_index     = it.entry_index;
        in_ch.entry_base_word = it.entry_base_word;
        in_ch.entry_mask_word = it.entry_mask_word;
        in_ch.valid           = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_results.push_back(predict_table_result(it));
        action_count[it.action]++;
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    // Waits until every result has been handed over and the block is quiet.
    task automatic wait_idle();
        in_ch.valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        wait_idle();
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        cfg_ch.valid = 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_FEATURE:    mirror_feature = value[0];
            CFG_WC_SUPPORT: mirror_wc      = value[0];
            CFG_ENABLED:    mirror_enabled = value[0];
            CFG_IN_USE:     mirror_in_use  = value[3:0];
            CFG_RAM_BYTES:  mirror_ram     = value;
            default: ;
        endcase
        reg_write_count++;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Mostly a fully enabled setup, with occasional disabled features and odd scan counts.
    task automatic randomize_config();
        int pick;
        write_register(CFG_FEATURE, 32'($urandom_range(0, 99) < 92));
        write_register(CFG_WC_SUPPORT, 32'($urandom_range(0, 99) < 92));
        write_register(CFG_ENABLED, 32'($urandom_range(0, 99) < 92));
        pick = $urandom_range(0, 99);
        if (pick < 65) write_register(CFG_IN_USE, 32'd8);
        else if (pick < 90) write_register(CFG_IN_USE, 32'($urandom_range(0, 8)));
        else write_register(CFG_IN_USE, 32'($urandom_range(9, 15)));
        pick = $urandom_range(0, 99);
        if (pick < 50) write_register(CFG_RAM_BYTES, 32'h1000_0000);
        else if (pick < 70) write_register(CFG_RAM_BYTES, 32'h0000_0000);
        else if (pick < 92) write_register(CFG_RAM_BYTES, $urandom);
        else write_register(CFG_RAM_BYTES, 32'hFFFF_FFFF);
    endtask

    // Precondition checks in their order, from the reset configuration upward.
    task automatic test_request_checks();
        send_item(make_item(ACT_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(ACT_REQUEST, 32'h0000_0000, 32'h0000_1000, 3'd0, '0, '0));
        send_item(make_item(ACT_REQUEST, 32'h8000_0000, 32'h0000_0000, 3'd0, '0, '0));
        send_item(make_item(ACT_REQUEST, 32'h8000_0000, 32'h0000_1000, 3'd0, '0, '0));
        write_register(CFG_FEATURE, 32'd1);
        send_item(make_item(ACT_REQUEST, 32'h8000_0000, 32'h0000_1000, 3'd0, '0, '0));
        write_register(CFG_WC_SUPPORT, 32'd1);
        send_item(make_item(ACT_REQUEST, 32'h8000_0000, 32'h0000_1000, 3'd0, '0, '0));
        write_register(CFG_ENABLED, 32'd1);
        write_register(CFG_RAM_BYTES, 32'hFFFF_FFFF);
        send_item(make_item(ACT_REQUEST, 32'hFFFF_F000, 32'h0000_1000, 3'd0, '0, '0));
        write_register(CFG_RAM_BYTES, 32'h1000_0000);
    endtask

    // Size rounding, alignment, placement and repeated requests.
    task automatic test_request_sizes();
        send_item(make_item(ACT_REQUEST, 32'h8000_0800, 32'h0000_1000, 3'd0, '0, '0));
        send_item(make_item(ACT_REQUEST, 32'h8010_0000, 32'h0020_0000, 3'd0, '0, '0));
        send_item(make_item(ACT_REQUEST, 32'h8000_0000, 32'h0000_0001, 3'd0, '0, '0));
        send_item(make_item(ACT_REQUEST, 32'h8000_0000, 32'h0000_0001, 3'd0, '0, '0));
        send_item(make_item(ACT_LOOKUP, 32'h8000_0FFF, '0, 3'd0, '0, '0));
        send_item(make_item(ACT_LOOKUP, 32'h8000_1000, '0, 3'd0, '0, '0));
        send_item(make_item(ACT_REQUEST, 32'hC000_0000, 32'hFFFF_FFFF, 3'd0, '0, '0));
        send_item(make_item(ACT_REQUEST, 32'hA000_0000, 32'h0100_0000, 3'd0, '0, '0));
    endtask

    // Conflicting types, a request over an uncached entry and all-ones entry words.
    task automatic test_type_conflicts();
        send_item(make_item(ACT_LOAD, '0, '0, 3'd3, 32'hB000_0006, 32'hF000_0800));
        send_item(make_item(ACT_REQUEST, 32'hB000_0000, 32'h0000_1000, 3'd0, '0, '0));
        send_item(make_item(ACT_LOAD, '0, '0, 3'd4, 32'hD000_0000, 32'hF000_0800));
        send_item(make_item(ACT_REQUEST, 32'hD000_0000, 32'h0000_1000, 3'd0, '0, '0));
        send_item(make_item(ACT_LOAD, '0, '0, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(ACT_LOOKUP, 32'hFFFF_FFFF, '0, 3'd0, '0, '0));
        send_item(make_item(ACT_LOAD, '0, '0, 3'd0, 32'h0000_0000, 32'h0000_0000));
    endtask

    // Scan counts of zero and above the table depth.
    task automatic test_scan_count();
        write_register(CFG_IN_USE, 32'd0);
        send_item(make_item(ACT_LOOKUP, 32'hC000_0000, '0, 3'd0, '0, '0));
        send_item(make_item(ACT_REQUEST, 32'hE000_0000, 32'h0000_1000, 3'd0, '0, '0));
        write_register(CFG_IN_USE, 32'd15);
        send_item(make_item(ACT_REQUEST, 32'hE000_0000, 32'h0000_1000, 3'd0, '0, '0));
        send_item(make_item(ACT_REQUEST, 32'h7000_0000, 32'h0000_1000, 3'd0, '0, '0));
        send_item(make_item(ACT_REQUEST, 32'h6000_0000, 32'h0000_1000, 3'd0, '0, '0));
        write_register(CFG_IN_USE, 32'd8);
    endtask

    // Random traffic under one idle profile, reconfigured between blocks.
    task automatic test_random_traffic(input int sender_pct, input int stall_pct);
        wait_idle();
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = stall_pct;
        for (int b = 0; b < BLOCKS; b++) begin
            randomize_config();
            for (int n = 0; n < BLOCK_ITEMS; n++) send_item(random_item());
        end
    endtask

    // Receiver side: ready is drawn at random at the falling edge.
    always @(negedge i_clk) begin
        out_ch.ready = ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Compares each result with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        range_result_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", 32'(out_ch.status), 32'd0);
            end else begin
                want = pending_results.pop_front();
                status_seen[want.status]++;
                if (out_ch.status !== want.status)
                    report_mismatch("status", 32'(out_ch.status), 32'(want.status));
                if (out_ch.found_type !== want.found_type)
                    report_mismatch("found_type", 32'(out_ch.found_type), 32'(want.found_type));
                if (out_ch.slot_used !== want.slot_used)
                    report_mismatch("slot_used", 32'(out_ch.slot_used), 32'(want.slot_used));
                if (out_ch.range_size !== want.range_size)
                    report_mismatch("range_size", 32'(out_ch.range_size), 32'(want.range_size));
            end
            result_count++;
        end
    end

    // Watchdog on cycles in which no transaction moves on any channel.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d cycles without a transaction", quiet_cycles);
            $display("variable_range_memory_type_table_tb failed");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin
        i_rst_n               = 1'b0;
        in_ch.valid           = 1'b0;
        in_ch.action          = ACT_LOOKUP;
        in_ch.address         = '0;
        in_ch.length_bytes    = '0;
        in_ch.entry_index     = '0;
        in_ch.entry_base_word = '0;
        in_ch.entry_mask_word = '0;
        out_ch.ready          = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = CFG_FEATURE;
        cfg_ch.data           = '0;
        mismatch_count        = 0;
        result_count          = 0;
        reg_write_count       = 0;
        quiet_cycles          = 0;
        sender_idle_pct       = 0;
        receiver_stall_pct    = 0;
        action_count          = '{default: 0};
        status_seen           = '{default: 0};
        for (int i = 0; i < DEPTH; i++) begin
            mirror_base[i] = '0;
            mirror_mask[i] = '0;
        end
        mirror_feature = 1'b0;
        mirror_wc      = 1'b0;
        mirror_enabled = 1'b0;
        mirror_in_use  = 4'd8;
        mirror_ram     = '0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_request_checks();
        test_request_sizes();
        test_type_conflicts();
        test_scan_count();
        test_random_traffic(0, 0);
        test_random_traffic(56, 0);
        test_random_traffic(0, 56);
        test_random_traffic(6, 6);

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Run covered %0d transactions (%0d requests, %0d lookups, %0d loads, %0d reserved) and %0d register writes.",
                 result_count, action_count[ACT_REQUEST], action_count[ACT_LOOKUP],
                 action_count[ACT_LOAD], action_count[ACT_RESERVED], reg_write_count);
        $display("Requests installed %0d, shadowed %0d, found no free entry %0d; lookups hit %0d, missed %0d.",
                 status_seen[ST_WRITTEN], status_seen[ST_NOT_EFFECTIVE], status_seen[ST_NO_FREE],
                 status_seen[ST_HIT], status_seen[ST_MISS]);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("variable_range_memory_type_table_tb passed");
        end else begin
            $display("variable_range_memory_type_table_tb failed");
        end
        $finish;
    end

endmodule
